// ===== hdl/broadcast_work_tracker_top_defines.svh =====
// Assertion macros for the broadcast work tracker.
`ifndef BROADCAST_WORK_TRACKER_TOP_DEFINES_SVH
`define BROADCAST_WORK_TRACKER_TOP_DEFINES_SVH

// Same-cycle implication.
`define BWT_ASSERT_NOW(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bwt assertion failed");

// Next-cycle implication.
`define BWT_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bwt assertion failed");

`endif

// ===== hdl/bwt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bwt_pkg
// Types and constants shared by the broadcast work tracker modules.
// ----------------------------------------------------------------------------
package bwt_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int IDX_W       = 4;
  localparam int OCC_W       = 5;
  localparam int ID_W        = 32;
  localparam int CPU_W       = 6;
  localparam int CNT_W       = 7;
  localparam logic [CNT_W-1:0] CNT_MAX = 7'd127;
  localparam int QDEPTH      = 2;
  localparam int QPTR_W      = 1;

  typedef enum logic [1:0] {
    CMD_ADD      = 2'd0,
    CMD_FETCH    = 2'd1,
    CMD_CHECKOUT = 2'd2,
    CMD_NONE     = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    KIND_ADDED   = 3'd0,
    KIND_SKIPPED = 3'd1,
    KIND_FULL    = 3'd2,
    KIND_FETCH   = 3'd3,
    KIND_ACK     = 3'd4,
    KIND_RETIRED = 3'd5
  } kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISP,
    S_FCHK,
    S_CCHK,
    S_HRD,
    S_HCHK,
    S_FIN
  } state_t;

  typedef struct packed {
    cmd_t              cmd;
    logic              skip;
    logic [CPU_W-1:0]  cpu;
    logic [ID_W-1:0]   last_id;
    logic              incl;
    logic              freef;
    logic [CNT_W-1:0]  online;
    logic [IDX_W-1:0]  slot;
  } req_t;

  typedef struct packed {
    logic [ID_W-1:0]   ident;
    logic [CPU_W-1:0]  origin;
    logic              excl;
    logic              freef;
    logic [CNT_W-1:0]  expected;
    logic [CNT_W-1:0]  checkins;
    logic [CNT_W-1:0]  checkouts;
  } entry_t;

  typedef struct packed {
    kind_t             kind;
    logic              found;
    logic [IDX_W-1:0]  slot;
    logic [ID_W-1:0]   id;
    logic              completed;
  } res_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? v : v + 1'b1;
  endfunction

endpackage

// ===== hdl/broadcast_work_tracker_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// broadcast_work_tracker_top
// Ring of 16 broadcast work entries with add, fetch and checkout requests.
// ----------------------------------------------------------------------------
// Requests pass a two-entry queue into a single engine that handles one
// request at a time against an entry RAM with one write and one registered
// read port. An add, or a checkout of an unoccupied slot, is answered at
// dispatch; a fetch reads ring entries from the head one by one (up to 16)
// until one matches; a checkout of an occupied slot reads and updates its
// entry and, when that reaches its expected count, reads the head entries
// and retires each while its checkouts cover its checkins. The RAM's one
// read per cycle is why entries are read one by one. The result register
// lets the queue keep taking requests while a result waits on the output.
module broadcast_work_tracker_top (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                in_cmd,
  input  logic [bwt_pkg::CPU_W-1:0] in_cpu_id,
  input  logic [bwt_pkg::ID_W-1:0]  in_last_id,
  input  logic                      in_include_current,
  input  logic                      in_free_when_done,
  input  logic [bwt_pkg::CNT_W-1:0] in_online_count,
  input  logic [bwt_pkg::IDX_W-1:0] in_slot,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [2:0]                out_reply_kind,
  output logic                      out_found,
  output logic [bwt_pkg::IDX_W-1:0] out_slot_out,
  output logic [bwt_pkg::ID_W-1:0]  out_work_id,
  output logic                      out_completed,
  output logic                      out_last
);
  import bwt_pkg::*;

  logic push_valid, push_ready, pop_valid, pop_ready;
  req_t push_req, pop_req;

  bwt_front u_front (
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_cmd             (in_cmd),
    .in_cpu_id          (in_cpu_id),
    .in_last_id         (in_last_id),
    .in_include_current (in_include_current),
    .in_free_when_done  (in_free_when_done),
    .in_online_count    (in_online_count),
    .in_slot            (in_slot),
    .push_valid         (push_valid),
    .push_ready         (push_ready),
    .push_req           (push_req)
  );

  bwt_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_req   (push_req),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_req    (pop_req)
  );

  bwt_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (pop_valid),
    .q_pop          (pop_ready),
    .q_req          (pop_req),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_reply_kind (out_reply_kind),
    .out_found      (out_found),
    .out_slot_out   (out_slot_out),
    .out_work_id    (out_work_id),
    .out_completed  (out_completed),
    .out_last       (out_last)
  );

endmodule

// ===== hdl/bwt_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bwt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bwt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

// ===== hdl/bwt_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bwt_front
// Takes requests, drops unknown commands and flags adds that will be skipped.
// ----------------------------------------------------------------------------
module bwt_front (
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               in_cmd,
  input  logic [bwt_pkg::CPU_W-1:0] in_cpu_id,
  input  logic [bwt_pkg::ID_W-1:0] in_last_id,
  input  logic                     in_include_current,
  input  logic                     in_free_when_done,
  input  logic [bwt_pkg::CNT_W-1:0] in_online_count,
  input  logic [bwt_pkg::IDX_W-1:0] in_slot,
  output logic                     push_valid,
  input  logic                     push_ready,
  output bwt_pkg::req_t            push_req
);
  import bwt_pkg::*;

  cmd_t cmd;

  assign cmd      = cmd_t'(in_cmd);
  assign in_ready = push_ready;
  // drop unknown commands: they give no result
  assign push_valid = in_valid && (cmd != CMD_NONE);

  always_comb begin
    push_req.cmd     = cmd;
    push_req.skip    = (cmd == CMD_ADD) && !in_include_current && (in_online_count == '0);
    push_req.cpu     = in_cpu_id;
    push_req.last_id = in_last_id;
    push_req.incl    = in_include_current;
    push_req.freef   = in_free_when_done;
    push_req.online  = in_online_count;
    push_req.slot    = in_slot;
  end

endmodule

// ===== hdl/bwt_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bwt_queue
// Short request queue between the front and the work engine.
// ----------------------------------------------------------------------------
module bwt_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  bwt_pkg::req_t push_req,
  output logic          pop_valid,
  input  logic          pop_ready,
  output bwt_pkg::req_t pop_req
);
  import bwt_pkg::*;

  req_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wp_r, wp_nxt;
  logic [QPTR_W-1:0] rp_r, rp_nxt;
  logic [QPTR_W:0]   cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign push_ready = (cnt_r < (QPTR_W+1)'(QDEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_req    = mem_r[rp_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wp_nxt  = do_push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = do_pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + (QPTR_W+1)'(do_push) - (QPTR_W+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= push_req;
    end
  end

endmodule

// ===== hdl/bwt_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bwt_back
// Work engine: ring storage, fetch scan, checkout and retirement from head.
// ----------------------------------------------------------------------------
module bwt_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      q_valid,
  output logic                      q_pop,
  input  bwt_pkg::req_t             q_req,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [2:0]                out_reply_kind,
  output logic                      out_found,
  output logic [bwt_pkg::IDX_W-1:0] out_slot_out,
  output logic [bwt_pkg::ID_W-1:0]  out_work_id,
  output logic                      out_completed,
  output logic                      out_last
);
  import bwt_pkg::*;

  state_t           state_r, state_nxt;
  req_t             req_r, req_nxt;
  logic [IDX_W-1:0] head_r, head_nxt;
  logic [IDX_W-1:0] tail_r, tail_nxt;
  logic [OCC_W-1:0] occ_r, occ_nxt;
  logic [ID_W-1:0]  ctr_r, ctr_nxt;
  logic [OCC_W-1:0] idx_r, idx_nxt;
  logic [IDX_W-1:0] addr_r, addr_nxt;
  res_t             pend_r, pend_nxt;
  res_t             out_r;
  logic             out_last_r;
  logic             out_valid_r;

  logic             emit, emit_last, fire, can_emit;
  res_t             emit_res;
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  entry_t           ram_wdata, rd;
  logic [ID_W-1:0]  new_id;
  logic [IDX_W-1:0] rel;
  logic             slot_busy, fetch_hit;
  logic [CNT_W-1:0] new_co;

  bwt_ram #(.WIDTH($bits(entry_t)), .DEPTH(QUEUE_DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rd)
  );

  assign can_emit  = !out_valid_r || out_ready;
  assign fire      = emit && can_emit;
  assign new_id    = (ctr_r == '0) ? ID_W'(1) : ctr_r;
  assign rel       = req_r.slot - head_r;
  assign slot_busy = ({1'b0, rel} < occ_r);
  assign fetch_hit = !(rd.excl && (rd.origin == req_r.cpu)) && (rd.ident > req_r.last_id);
  assign new_co    = sat_inc(rd.checkouts);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (q_valid) state_nxt = S_DISP;
      S_DISP: begin
        case (req_r.cmd)
          CMD_FETCH:    if (occ_r != '0) state_nxt = S_FCHK;
                        else if (fire) state_nxt = S_IDLE;
          CMD_CHECKOUT: if (slot_busy) state_nxt = S_CCHK;
                        else if (fire) state_nxt = S_IDLE;
          default:      if (fire) state_nxt = S_IDLE;
        endcase
      end
      S_FCHK: if (fire) state_nxt = S_IDLE;
      S_CCHK: state_nxt = (new_co >= rd.expected) ? S_HRD : S_FIN;
      S_HRD:  state_nxt = S_HCHK;
      S_HCHK: if (occ_r == '0 || rd.checkouts < rd.checkins) state_nxt = S_FIN;
      S_FIN:  if (fire) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and results
  always_comb begin
    q_pop     = 1'b0;
    req_nxt   = req_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    occ_nxt   = occ_r;
    ctr_nxt   = ctr_r;
    idx_nxt   = idx_r;
    addr_nxt  = addr_r;
    pend_nxt  = pend_r;
    emit      = 1'b0;
    emit_last = 1'b1;
    emit_res  = '{kind: KIND_ADDED, found: 1'b0, slot: '0, id: '0, completed: 1'b0};
    ram_we    = 1'b0;
    ram_waddr = addr_r;
    ram_wdata = rd;
    ram_raddr = addr_r;
    case (state_r)
      S_IDLE: begin
        q_pop = q_valid;
        if (q_valid) req_nxt = q_req;
      end
      S_DISP: begin
        case (req_r.cmd)
          CMD_ADD: begin
            emit = 1'b1;
            if (req_r.skip) begin
              emit_res.kind = KIND_SKIPPED;
            end else if (occ_r == OCC_W'(QUEUE_DEPTH)) begin
              emit_res.kind = KIND_FULL;
            end else begin
              emit_res.slot = tail_r;
              emit_res.id   = new_id;
              ram_waddr     = tail_r;
              ram_wdata     = '{ident: new_id, origin: req_r.cpu, excl: !req_r.incl,
                                freef: req_r.freef, expected: req_r.online,
                                checkins: CNT_W'(!req_r.incl),
                                checkouts: CNT_W'(!req_r.incl)};
              if (fire) begin
                ram_we   = 1'b1;
                tail_nxt = tail_r + 1'b1;
                occ_nxt  = occ_r + 1'b1;
                ctr_nxt  = new_id + 1'b1;
              end
            end
          end
          CMD_FETCH: begin
            emit_res.kind = KIND_FETCH;
            if (occ_r == '0) begin
              emit = 1'b1;
            end else begin
              idx_nxt   = '0;
              addr_nxt  = head_r;
              ram_raddr = head_r;
            end
          end
          default: begin
            emit_res.kind = KIND_ACK;
            emit_res.slot = req_r.slot;
            if (slot_busy) begin
              pend_nxt  = emit_res;
              addr_nxt  = req_r.slot;
              ram_raddr = req_r.slot;
            end else begin
              emit = 1'b1;
            end
          end
        endcase
      end
      S_FCHK: begin
        emit_res.kind = KIND_FETCH;
        if (fetch_hit) begin
          emit           = 1'b1;
          emit_res.found = 1'b1;
          emit_res.slot  = addr_r;
          emit_res.id    = rd.ident;
          ram_wdata.checkins = sat_inc(rd.checkins);
          ram_we         = fire;
        end else if (idx_r + 1'b1 == occ_r) begin
          emit = 1'b1;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          addr_nxt  = addr_r + 1'b1;
          ram_raddr = addr_r + 1'b1;
        end
      end
      S_CCHK: begin
        ram_wdata.checkouts = new_co;
        ram_we = 1'b1;
      end
      S_HRD: begin
        addr_nxt  = head_r;
        ram_raddr = head_r;
      end
      S_HCHK: begin
        if (occ_r != '0 && rd.checkouts >= rd.checkins) begin
          // hold previous result until we know this one follows
          emit      = 1'b1;
          emit_last = 1'b0;
          emit_res  = pend_r;
          if (fire) begin
            pend_nxt  = '{kind: KIND_RETIRED, found: 1'b0, slot: head_r, id: rd.ident,
                          completed: !rd.freef};
            head_nxt  = head_r + 1'b1;
            occ_nxt   = occ_r - 1'b1;
            addr_nxt  = head_r + 1'b1;
            ram_raddr = head_r + 1'b1;
          end
        end
      end
      S_FIN: begin
        emit     = 1'b1;
        emit_res = pend_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      occ_r       <= '0;
      ctr_r       <= ID_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      occ_r   <= occ_nxt;
      ctr_r   <= ctr_nxt;
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    req_r  <= req_nxt;
    idx_r  <= idx_nxt;
    addr_r <= addr_nxt;
    pend_r <= pend_nxt;
    if (fire) begin
      out_r      <= emit_res;
      out_last_r <= emit_last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_reply_kind = 3'(out_r.kind);
  assign out_found      = out_r.found;
  assign out_slot_out   = out_r.slot;
  assign out_work_id    = out_r.id;
  assign out_completed  = out_r.completed;
  assign out_last       = out_last_r;

endmodule

// ===== hdl/bwt_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bwt_checker
// Port-level checks on the broadcast work tracker's result channel.
// ----------------------------------------------------------------------------
`include "broadcast_work_tracker_top_defines.svh"

module bwt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_reply_kind,
  input logic        out_found,
  input logic [3:0]  out_slot_out,
  input logic [31:0] out_work_id,
  input logic        out_completed,
  input logic        out_last
);
  import bwt_pkg::*;

  `BWT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_work_id) && $stable(out_reply_kind) && $stable(out_last))
  `BWT_ASSERT_NOW(a_kind_range, clk, rst_n, out_valid, out_reply_kind <= 3'(KIND_RETIRED))
  `BWT_ASSERT_NOW(a_miss_zero, clk, rst_n, out_valid && out_reply_kind == 3'(KIND_FETCH) && !out_found, out_work_id == '0 && out_slot_out == '0)
  `BWT_ASSERT_NOW(a_add_id, clk, rst_n, out_valid && out_reply_kind == 3'(KIND_ADDED), out_work_id != '0 && out_last)

endmodule

bind broadcast_work_tracker_top bwt_checker u_bwt_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_reply_kind (out_reply_kind),
  .out_found      (out_found),
  .out_slot_out   (out_slot_out),
  .out_work_id    (out_work_id),
  .out_completed  (out_completed),
  .out_last       (out_last)
);

// ===== dv/tb_broadcast_work_tracker_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_broadcast_work_tracker_top
// Self-checking bench for the broadcast work tracker. A queue of requests
// feeds a valid/ready driver; a monitor checks every result against a
// behavioral ring model kept in the bench, across several idle/stall phases.
// ----------------------------------------------------------------------------
module tb_broadcast_work_tracker_top;
  import bwt_pkg::*;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [CPU_W-1:0] cpu;
    logic [ID_W-1:0]  last_id;
    logic             incl;
    logic             freef;
    logic [CNT_W-1:0] online;
    logic [IDX_W-1:0] slot;
  } request_t;

  typedef struct packed {
    logic [2:0]       kind;
    logic             found;
    logic [IDX_W-1:0] slot;
    logic [ID_W-1:0]  id;
    logic             completed;
    logic             last;
  } reply_t;

  localparam int WATCHDOG_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_cmd = '0;
  logic [CPU_W-1:0] in_cpu_id = '0;
  logic [ID_W-1:0] in_last_id = '0;
  logic in_include_current = 1'b0;
  logic in_free_when_done = 1'b0;
  logic [CNT_W-1:0] in_online_count = '0;
  logic [IDX_W-1:0] in_slot = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [2:0] out_reply_kind;
  logic out_found;
  logic [IDX_W-1:0] out_slot_out;
  logic [ID_W-1:0] out_work_id;
  logic out_completed;
  logic out_last;

  broadcast_work_tracker_top dut (.*);

  always #2 clk = ~clk;

  // ring model
  logic [ID_W-1:0]  ring_ident [QUEUE_DEPTH];
  logic [CPU_W-1:0] ring_origin [QUEUE_DEPTH];
  logic             ring_excl [QUEUE_DEPTH];
  logic             ring_free [QUEUE_DEPTH];
  logic [CNT_W-1:0] ring_expected [QUEUE_DEPTH];
  logic [CNT_W-1:0] ring_checkins [QUEUE_DEPTH];
  logic [CNT_W-1:0] ring_checkouts [QUEUE_DEPTH];
  int unsigned      ring_head = 0, ring_tail = 0, ring_count = 0;
  logic [ID_W-1:0]  next_ident = 1;
  logic [ID_W-1:0]  issued_ids [$];

  request_t pending_requests [$];
  reply_t   expected_replies [$];
  int       error_count = 0;
  int       replies_seen = 0, retired_seen = 0, full_seen = 0;
  int       send_idle_pct = 0, recv_stall_pct = 0;
  bit       hold_sender = 0;
  int       idle_cycles = 0;

  function automatic logic [CNT_W-1:0] bump(logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? v : v + 1'b1;
  endfunction

  function automatic reply_t mk(kind_t k, logic f, logic [IDX_W-1:0] s,
                                logic [ID_W-1:0] id, logic c);
    reply_t r;
    r.kind = k; r.found = f; r.slot = s; r.id = id; r.completed = c; r.last = 1'b0;
    return r;
  endfunction

  task automatic predict_request(request_t q);
    reply_t rs [$];
    int unsigned s, h;
    logic [ID_W-1:0] id;
    bit hit;
    case (q.cmd)
      CMD_ADD: begin
        if (!q.incl && q.online == 0) rs.push_back(mk(KIND_SKIPPED, 0, 0, 0, 0));
        else if (ring_count >= QUEUE_DEPTH) rs.push_back(mk(KIND_FULL, 0, 0, 0, 0));
        else begin
          id = next_ident;
          next_ident = next_ident + 1'b1;
          if (id == 0) begin
            id = next_ident;
            next_ident = next_ident + 1'b1;
          end
          s = ring_tail;
          ring_ident[s] = id;
          ring_origin[s] = q.cpu;
          ring_excl[s] = !q.incl;
          ring_free[s] = q.freef;
          ring_expected[s] = q.online;
          ring_checkins[s] = CNT_W'(!q.incl);
          ring_checkouts[s] = CNT_W'(!q.incl);
          ring_tail = (s + 1) % QUEUE_DEPTH;
          ring_count++;
          issued_ids.push_back(id);
          rs.push_back(mk(KIND_ADDED, 0, IDX_W'(s), id, 0));
        end
      end
      CMD_FETCH: begin
        hit = 0;
        for (int i = 0; i < ring_count && !hit; i++) begin
          s = (ring_head + i) % QUEUE_DEPTH;
          if (!(ring_excl[s] && ring_origin[s] == q.cpu) && ring_ident[s] > q.last_id) begin
            ring_checkins[s] = bump(ring_checkins[s]);
            rs.push_back(mk(KIND_FETCH, 1, IDX_W'(s), ring_ident[s], 0));
            hit = 1;
          end
        end
        if (!hit) rs.push_back(mk(KIND_FETCH, 0, 0, 0, 0));
      end
      CMD_CHECKOUT: begin
        rs.push_back(mk(KIND_ACK, 0, q.slot, 0, 0));
        s = q.slot;
        if (((s + QUEUE_DEPTH - ring_head) % QUEUE_DEPTH) < ring_count) begin
          ring_checkouts[s] = bump(ring_checkouts[s]);
          if (ring_checkouts[s] >= ring_expected[s]) begin
            while (ring_count > 0) begin
              h = ring_head;
              if (ring_checkouts[h] < ring_checkins[h]) break;
              rs.push_back(mk(KIND_RETIRED, 0, IDX_W'(h), ring_ident[h], !ring_free[h]));
              ring_head = (h + 1) % QUEUE_DEPTH;
              ring_count--;
            end
          end
        end
      end
      default: ;
    endcase
    if (rs.size() > 0) rs[rs.size()-1].last = 1'b1;
    foreach (rs[i]) expected_replies.push_back(rs[i]);
  endtask

  function automatic request_t rq(logic [1:0] c, logic [CPU_W-1:0] cpu,
                                  logic [ID_W-1:0] lid, logic inc, logic fr,
                                  logic [CNT_W-1:0] on, logic [IDX_W-1:0] sl);
    request_t q;
    q.cmd = c; q.cpu = cpu; q.last_id = lid; q.incl = inc; q.freef = fr;
    q.online = on; q.slot = sl;
    return q;
  endfunction

  // random request; mostly well-formed traffic, some noise
  function automatic request_t random_request();
    int p = $urandom_range(0, 99);
    request_t q;
    q = rq(2'($urandom_range(0, 2)), CPU_W'($urandom), ID_W'($urandom_range(0, 40)),
           1'($urandom), 1'($urandom), CNT_W'($urandom_range(0, 4)), IDX_W'($urandom));
    if (p < 3) q.cmd = CMD_NONE;
    else if (p < 8) q.last_id = ID_W'($urandom);
    else if (p < 11) q.online = CNT_W'($urandom_range(0, 127));
    else if (p < 14) q.cpu = CPU_W'($urandom_range(0, 1));
    return q;
  endfunction

  // driver
  always @(posedge clk) begin
    request_t q;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (pending_requests.size() > 0 && !hold_sender &&
          $urandom_range(0, 99) >= send_idle_pct) begin
        q = pending_requests.pop_front();
        in_valid <= 1'b1;
        in_cmd <= q.cmd;
        in_cpu_id <= q.cpu;
        in_last_id <= q.last_id;
        in_include_current <= q.incl;
        in_free_when_done <= q.freef;
        in_online_count <= q.online;
        in_slot <= q.slot;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // predict at acceptance
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready)
      predict_request(rq(in_cmd, in_cpu_id, in_last_id, in_include_current,
                         in_free_when_done, in_online_count, in_slot));
  end

  // monitor
  always @(posedge clk) begin
    reply_t got, want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      if (out_valid && out_ready) begin
        got = {out_reply_kind, out_found, out_slot_out, out_work_id, out_completed, out_last};
        replies_seen++;
        if (got.kind == KIND_RETIRED) retired_seen++;
        if (got.kind == KIND_FULL) full_seen++;
        if (expected_replies.size() == 0) begin
          $display("%0t: unexpected reply actual %p", $time, got);
          error_count++;
        end else begin
          want = expected_replies.pop_front();
          if (got !== want) begin
            $display("%0t: reply mismatch expected %p actual %p", $time, want, got);
            error_count++;
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_broadcast_work_tracker_top failed");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_requests.size() > 0 || in_valid || expected_replies.size() > 0)
      @(posedge clk);
  endtask

  task automatic random_phase(int n, int idle, int stall);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    repeat (n) pending_requests.push_back(random_request());
    wait_drained();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    // directed: skip, adds, fetch/extremes, full ring, bad checkout
    pending_requests.push_back(rq(CMD_ADD, 0, 0, 0, 0, 0, 0));
    pending_requests.push_back(rq(CMD_FETCH, 63, 0, 1, 1, 127, 15));
    pending_requests.push_back(rq(CMD_CHECKOUT, 0, 0, 0, 0, 0, 15));
    pending_requests.push_back(rq(CMD_ADD, 63, '1, 0, 1, 64, 15));
    pending_requests.push_back(rq(CMD_ADD, 5, 0, 1, 0, 1, 0));
    pending_requests.push_back(rq(CMD_FETCH, 63, 0, 0, 0, 0, 0));
    pending_requests.push_back(rq(CMD_FETCH, 5, '1, 0, 0, 0, 0));
    pending_requests.push_back(rq(CMD_FETCH, 5, 0, 0, 0, 0, 0));
    pending_requests.push_back(rq(CMD_NONE, 42, 32'h5555_aaaa, 1, 1, 127, 10));
    for (int i = 0; i < 15; i++)
      pending_requests.push_back(rq(CMD_ADD, CPU_W'(i), 0, 1, i[0], 1, 0));
    pending_requests.push_back(rq(CMD_ADD, 1, 0, 1, 0, 1, 0));
    wait_drained();
    // fetch, then check out each ring slot twice, in slot order
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      pending_requests.push_back(rq(CMD_FETCH, 7, 0, 0, 0, 0, 0));
      pending_requests.push_back(rq(CMD_CHECKOUT, 7, 0, 0, 0, 0, IDX_W'(i)));
      pending_requests.push_back(rq(CMD_CHECKOUT, 8, 0, 0, 0, 0, IDX_W'(i)));
    end
    wait_drained();
    random_phase(27, 0, 0);
    random_phase(27, 77, 0);
    // sender pauses until every reply is back
    hold_sender = 1;
    wait_drained();
    hold_sender = 0;
    random_phase(27, 0, 77);
    random_phase(27, 17, 17);
    repeat (40) @(posedge clk);
    $display("Covered %0d replies incl. %0d retirements and %0d full-ring rejects,",
             replies_seen, retired_seen, full_seen);
    $display("across no-idle, sender-idle, receiver-stall and mixed phases.");
    if (error_count == 0 && expected_replies.size() == 0)
      $display("tb_broadcast_work_tracker_top passed");
    else
      $display("tb_broadcast_work_tracker_top failed");
    $finish;
  end
endmodule

// ===== broadcast_work_tracker_top.f =====
+incdir+hdl
hdl/bwt_pkg.sv
hdl/bwt_ram.sv
hdl/bwt_front.sv
hdl/bwt_queue.sv
hdl/bwt_back.sv
hdl/broadcast_work_tracker_top.sv
hdl/bwt_checker.sv
dv/tb_broadcast_work_tracker_top.sv
